[src/cbkv_pkg.sv]
// ----------------------------------------------------------------------------
// Crit-bit key-value table package
// Request and result beat types, request and status codes, fixed widths.
// ----------------------------------------------------------------------------
package cbkv_pkg;

    localparam int KEY_BITS   = 64;
    localparam int SPLIT_BITS = 6;
    localparam int DEPTH_BITS = 7;
    localparam int MAX_DEPTH  = 64;
    localparam int SCAN_STEPS = 8;
    localparam int SCAN_BITS  = 8;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;
    localparam logic [1:0] REQ_OTHER  = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_DUPLICATE = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] key;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
    } res_t;

    typedef struct packed {
        logic node;
        logic c0;
        logic c1;
    } nm_wen_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fl_cmd_t;

endpackage

[src/critbit_key_value_table_top.sv]
// ----------------------------------------------------------------------------
// Crit-bit key-value table
// Insert, remove and lookup of 64-bit keys in a crit-bit tree held in a node
// memory, branching from the least significant key bit upward.
// ----------------------------------------------------------------------------
// One request at a time: busy is high from the cycle after start is taken
// until the result beat, which is shown on result with done for exactly one
// cycle and cannot be held off. A lookup or remove walks the tree, one node
// memory read per level and at most 64 levels; an insert walks it, then runs
// the byte-wide lowest-bit search and writes a new leaf and middle node. A
// full insert, a request that finds the tree empty or an other request is
// answered at once, with busy staying low, and an insert into an empty tree
// writes a single leaf. The table is usable right after reset, with no
// clearing pass.
module critbit_key_value_table_top #(
    parameter int MAX_KEYS   = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  cbkv_pkg::req_t  req,
    output logic            done,
    output cbkv_pkg::res_t  result
);

    localparam int SLOTS = 2 * MAX_KEYS;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_WALK  = 9'b000000010,
        S_EPOP  = 9'b000000100,
        S_SCAN  = 9'b000001000,
        S_POP1  = 9'b000010000,
        S_POP2  = 9'b000100000,
        S_WMID  = 9'b001000000,
        S_WLINK = 9'b010000000,
        S_RFREE = 9'b100000000
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    cbkv_pkg::req_t  req_reg;
    cbkv_pkg::res_t  result_reg;
    logic            done_reg;
    logic [SW-1:0]   root_reg;
    logic            empty_reg;
    logic [SW-1:0]   cur_reg;
    logic [cbkv_pkg::DEPTH_BITS-1:0] depth_reg;
    logic [SW-1:0]   p_reg;
    logic            side_reg;
    logic            atroot_reg;
    logic [SW-1:0]   gp_reg;
    logic            gside_reg;
    logic            groot_reg;
    logic [SW-1:0]   sib_reg;
    logic [SW-1:0]   leaf_slot_reg;
    logic [SW-1:0]   mid_slot_reg;

    cbkv_pkg::nm_wen_t nm_wen;
    logic [SW-1:0]     nm_waddr;
    logic              nm_w_leaf;
    logic [63:0]       nm_w_key;
    logic [5:0]        nm_w_split;
    logic [SW-1:0]     nm_w_c0;
    logic [SW-1:0]     nm_w_c1;
    logic              nm_re;
    logic [SW-1:0]     nm_raddr;
    logic              q_leaf;
    logic [63:0]       q_key;
    logic [5:0]        q_split;
    logic [VALUE_BITS-1:0] q_pay;
    logic [SW-1:0]     q_c0;
    logic [SW-1:0]     q_c1;

    cbkv_pkg::fl_cmd_t fl_cmd;
    logic [SW-1:0]     fl_push_slot;
    logic [SW-1:0]     fl_slot;
    logic [CW-1:0]     fl_count;

    logic              sc_start;
    logic              sc_done;
    logic [5:0]        sc_pos;

    logic              accept;
    logic              is_ins;
    logic              is_rem;
    logic              ins_full;
    logic              go_walk;
    logic              q_bit;
    logic [63:0]       pref_mask;
    logic [63:0]       mid_mask;
    logic              pref_miss;
    logic              key_hit;
    logic              walk_stop;
    logic [SW-1:0]     walk_next;
    logic [SW-1:0]     walk_sib;
    logic              rem_hit;
    logic              mid_kb;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign accept = start && (state_reg == S_IDLE);

    assign ins_full = (req.req_type == cbkv_pkg::REQ_INSERT) && (fl_count < CW'(2));
    assign go_walk  = (req.req_type != cbkv_pkg::REQ_OTHER) && !empty_reg && !ins_full;

    assign is_ins    = (req_reg.req_type == cbkv_pkg::REQ_INSERT);
    assign is_rem    = (req_reg.req_type == cbkv_pkg::REQ_REMOVE);
    assign q_bit     = req_reg.key[q_split];
    assign pref_mask = (64'd1 << q_split) - 64'd1;
    assign pref_miss = (req_reg.key & pref_mask) != q_key;
    assign key_hit   = (q_key == req_reg.key);
    assign walk_stop = q_leaf || (depth_reg == cbkv_pkg::DEPTH_BITS'(cbkv_pkg::MAX_DEPTH))
                       || (is_ins && pref_miss);
    assign walk_next = q_bit ? q_c1 : q_c0;
    assign walk_sib  = q_bit ? q_c0 : q_c1;
    assign rem_hit   = q_leaf && key_hit;
    assign mid_mask  = (64'd1 << sc_pos) - 64'd1;
    assign mid_kb    = req_reg.key[sc_pos];
    assign sc_start  = (state_reg == S_WALK) && walk_stop && is_ins && !key_hit;

    always_comb
    begin
        state_next   = state_reg;
        nm_wen       = '0;
        nm_waddr     = '0;
        nm_w_leaf    = 1'b0;
        nm_w_key     = req_reg.key;
        nm_w_split   = sc_pos;
        nm_w_c0      = '0;
        nm_w_c1      = '0;
        nm_re        = 1'b0;
        nm_raddr     = walk_next;
        fl_cmd       = '0;
        fl_push_slot = cur_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                nm_raddr = root_reg;
                if (start)
                begin
                    if (go_walk)
                    begin
                        nm_re      = 1'b1;
                        state_next = S_WALK;
                    end
                    else if ((req.req_type == cbkv_pkg::REQ_INSERT) && !ins_full)
                    begin
                        fl_cmd.pop = 1'b1;
                        state_next = S_EPOP;
                    end
                end
            end
            S_WALK:
            begin
                if (!walk_stop)
                begin
                    nm_re = 1'b1;
                end
                else if (is_ins)
                begin
                    state_next = key_hit ? S_IDLE : S_SCAN;
                end
                else if (is_rem && rem_hit)
                begin
                    fl_cmd.push = 1'b1;
                    if (depth_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        nm_waddr   = gp_reg;
                        nm_w_c0    = sib_reg;
                        nm_w_c1    = sib_reg;
                        nm_wen.c0  = !groot_reg && !gside_reg;
                        nm_wen.c1  = !groot_reg && gside_reg;
                        state_next = S_RFREE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EPOP:
            begin
                nm_waddr    = fl_slot;
                nm_wen.node = 1'b1;
                nm_w_leaf   = 1'b1;
                state_next  = S_IDLE;
            end
            S_SCAN:
            begin
                if (sc_done)
                begin
                    fl_cmd.pop = 1'b1;
                    state_next = S_POP1;
                end
            end
            S_POP1:
            begin
                fl_cmd.pop = 1'b1;
                state_next = S_POP2;
            end
            S_POP2:
            begin
                nm_waddr    = leaf_slot_reg;
                nm_wen.node = 1'b1;
                nm_w_leaf   = 1'b1;
                state_next  = S_WMID;
            end
            S_WMID:
            begin
                nm_waddr   = mid_slot_reg;
                nm_wen     = '{node: 1'b1, c0: 1'b1, c1: 1'b1};
                nm_w_key   = req_reg.key & mid_mask;
                nm_w_c0    = mid_kb ? cur_reg : leaf_slot_reg;
                nm_w_c1    = mid_kb ? leaf_slot_reg : cur_reg;
                state_next = S_WLINK;
            end
            S_WLINK:
            begin
                nm_waddr   = p_reg;
                nm_w_c0    = mid_slot_reg;
                nm_w_c1    = mid_slot_reg;
                nm_wen.c0  = !atroot_reg && !side_reg;
                nm_wen.c1  = !atroot_reg && side_reg;
                state_next = S_IDLE;
            end
            S_RFREE:
            begin
                fl_cmd.push  = 1'b1;
                fl_push_slot = p_reg;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            result_reg    <= '0;
            done_reg      <= 1'b0;
            root_reg      <= '0;
            empty_reg     <= 1'b1;
            cur_reg       <= '0;
            depth_reg     <= '0;
            p_reg         <= '0;
            side_reg      <= 1'b0;
            atroot_reg    <= 1'b1;
            gp_reg        <= '0;
            gside_reg     <= 1'b0;
            groot_reg     <= 1'b1;
            sib_reg       <= '0;
            leaf_slot_reg <= '0;
            mid_slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg              <= req;
                        result_reg.value_out <= '0;
                        cur_reg              <= root_reg;
                        depth_reg            <= '0;
                        p_reg                <= '0;
                        side_reg             <= 1'b0;
                        atroot_reg           <= 1'b1;
                        groot_reg            <= 1'b1;
                        if (ins_full)
                        begin
                            result_reg.status <= cbkv_pkg::STATUS_FULL;
                            done_reg          <= 1'b1;
                        end
                        else if (!go_walk && (req.req_type != cbkv_pkg::REQ_INSERT))
                        begin
                            result_reg.status <= cbkv_pkg::STATUS_NOT_FOUND;
                            done_reg          <= 1'b1;
                        end
                    end
                end
                S_WALK:
                begin
                    if (!walk_stop)
                    begin
                        gp_reg     <= p_reg;
                        gside_reg  <= side_reg;
                        groot_reg  <= atroot_reg;
                        p_reg      <= cur_reg;
                        side_reg   <= q_bit;
                        atroot_reg <= 1'b0;
                        sib_reg    <= walk_sib;
                        cur_reg    <= walk_next;
                        depth_reg  <= depth_reg + cbkv_pkg::DEPTH_BITS'(1);
                    end
                    else if (is_ins)
                    begin
                        if (key_hit)
                        begin
                            result_reg.status <= cbkv_pkg::STATUS_DUPLICATE;
                            done_reg          <= 1'b1;
                        end
                    end
                    else if (is_rem && rem_hit)
                    begin
                        result_reg.value_out <= 32'(q_pay);
                        if (depth_reg == '0)
                        begin
                            empty_reg         <= 1'b1;
                            root_reg          <= '0;
                            result_reg.status <= cbkv_pkg::STATUS_OK;
                            done_reg          <= 1'b1;
                        end
                        else if (groot_reg)
                        begin
                            root_reg <= sib_reg;
                        end
                    end
                    else if (!is_rem && rem_hit)
                    begin
                        result_reg.status    <= cbkv_pkg::STATUS_OK;
                        result_reg.value_out <= 32'(q_pay);
                        done_reg             <= 1'b1;
                    end
                    else
                    begin
                        result_reg.status <= cbkv_pkg::STATUS_NOT_FOUND;
                        done_reg          <= 1'b1;
                    end
                end
                S_EPOP:
                begin
                    root_reg          <= fl_slot;
                    empty_reg         <= 1'b0;
                    result_reg.status <= cbkv_pkg::STATUS_OK;
                    done_reg          <= 1'b1;
                end
                S_SCAN:
                begin
                end
                S_POP1:
                begin
                    leaf_slot_reg <= fl_slot;
                end
                S_POP2:
                begin
                    mid_slot_reg <= fl_slot;
                end
                S_WMID:
                begin
                end
                S_WLINK:
                begin
                    if (atroot_reg)
                    begin
                        root_reg <= mid_slot_reg;
                    end
                    result_reg.status <= cbkv_pkg::STATUS_OK;
                    done_reg          <= 1'b1;
                end
                S_RFREE:
                begin
                    result_reg.status <= cbkv_pkg::STATUS_OK;
                    done_reg          <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    cbkv_node_mem #(
        .SLOTS (SLOTS),
        .VW    (VALUE_BITS)
    ) u_node_mem (
        .clk     (clk),
        .wen     (nm_wen),
        .waddr   (nm_waddr),
        .w_leaf  (nm_w_leaf),
        .w_key   (nm_w_key),
        .w_split (nm_w_split),
        .w_pay   (VALUE_BITS'(req_reg.value)),
        .w_c0    (nm_w_c0),
        .w_c1    (nm_w_c1),
        .re      (nm_re),
        .raddr   (nm_raddr),
        .q_leaf  (q_leaf),
        .q_key   (q_key),
        .q_split (q_split),
        .q_pay   (q_pay),
        .q_c0    (q_c0),
        .q_c1    (q_c1)
    );

    cbkv_free_list #(
        .SLOTS (SLOTS)
    ) u_free_list (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (fl_cmd),
        .push_slot  (fl_push_slot),
        .pop_slot   (fl_slot),
        .free_count (fl_count)
    );

    cbkv_bitscan u_bitscan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sc_start),
        .diff  (q_key ^ req_reg.key),
        .done  (sc_done),
        .pos   (sc_pos)
    );

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result beat without a request in progress");

    a_free_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        fl_count <= CW'(SLOTS))
        else $error("free slot count above slot total");

    a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == cbkv_pkg::STATUS_FULL))
        |-> (req_reg.req_type == cbkv_pkg::REQ_INSERT))
        else $error("full status on a request that is not an insert");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (depth_reg <= cbkv_pkg::DEPTH_BITS'(cbkv_pkg::MAX_DEPTH)))
        else $error("tree walk deeper than the depth limit");
`endif

endmodule

[src/cbkv_node_mem.sv]
// ----------------------------------------------------------------------------
// Crit-bit node memory
// Slot storage: leaf flag, key or prefix, split position, payload and the
// two child links, one write address and one registered read per cycle.
// ----------------------------------------------------------------------------
module cbkv_node_mem #(
    parameter int SLOTS = 2048,
    parameter int VW    = 32
) (
    input  logic                      clk,
    input  cbkv_pkg::nm_wen_t         wen,
    input  logic [$clog2(SLOTS)-1:0]  waddr,
    input  logic                      w_leaf,
    input  logic [63:0]               w_key,
    input  logic [5:0]                w_split,
    input  logic [VW-1:0]             w_pay,
    input  logic [$clog2(SLOTS)-1:0]  w_c0,
    input  logic [$clog2(SLOTS)-1:0]  w_c1,
    input  logic                      re,
    input  logic [$clog2(SLOTS)-1:0]  raddr,
    output logic                      q_leaf,
    output logic [63:0]               q_key,
    output logic [5:0]                q_split,
    output logic [VW-1:0]             q_pay,
    output logic [$clog2(SLOTS)-1:0]  q_c0,
    output logic [$clog2(SLOTS)-1:0]  q_c1
);

    localparam int SW = $clog2(SLOTS);

    logic          leaf_mem  [SLOTS];
    logic [63:0]   key_mem   [SLOTS];
    logic [5:0]    split_mem [SLOTS];
    logic [VW-1:0] pay_mem   [SLOTS];
    logic [SW-1:0] c0_mem    [SLOTS];
    logic [SW-1:0] c1_mem    [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wen.node)
        begin
            leaf_mem[waddr]  <= w_leaf;
            key_mem[waddr]   <= w_key;
            split_mem[waddr] <= w_split;
            pay_mem[waddr]   <= w_pay;
        end
        if (wen.c0)
        begin
            c0_mem[waddr] <= w_c0;
        end
        if (wen.c1)
        begin
            c1_mem[waddr] <= w_c1;
        end
        if (re)
        begin
            q_leaf  <= leaf_mem[raddr];
            q_key   <= key_mem[raddr];
            q_split <= split_mem[raddr];
            q_pay   <= pay_mem[raddr];
            q_c0    <= c0_mem[raddr];
            q_c1    <= c1_mem[raddr];
        end
    end

endmodule

[src/cbkv_free_list.sv]
// ----------------------------------------------------------------------------
// Crit-bit free slot list
// Freed slots go on a stack; slots never used yet come from a fill counter.
// A popped slot is valid in the cycle after the pop.
// ----------------------------------------------------------------------------
module cbkv_free_list #(
    parameter int SLOTS = 2048
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cbkv_pkg::fl_cmd_t              cmd,
    input  logic [$clog2(SLOTS)-1:0]       push_slot,
    output logic [$clog2(SLOTS)-1:0]       pop_slot,
    output logic [$clog2(SLOTS+1)-1:0]     free_count
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [SW-1:0] stack_mem [SLOTS];
    logic [CW-1:0] sp_reg;
    logic [CW-1:0] fresh_reg;
    logic [CW-1:0] sp_dec;
    logic [SW-1:0] stack_q_reg;
    logic [SW-1:0] fresh_q_reg;
    logic          from_stack_reg;

    assign sp_dec     = sp_reg - CW'(1);
    assign free_count = CW'(SLOTS) - fresh_reg + sp_reg;
    assign pop_slot   = from_stack_reg ? stack_q_reg : fresh_q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[sp_reg[SW-1:0]] <= push_slot;
        end
        if (cmd.pop)
        begin
            stack_q_reg <= stack_mem[sp_dec[SW-1:0]];
            fresh_q_reg <= fresh_reg[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg         <= '0;
            fresh_reg      <= '0;
            from_stack_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            sp_reg <= sp_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            from_stack_reg <= (sp_reg != '0);
            if (sp_reg != '0)
            begin
                sp_reg <= sp_dec;
            end
            else
            begin
                fresh_reg <= fresh_reg + CW'(1);
            end
        end
    end

endmodule

[src/cbkv_bitscan.sv]
// ----------------------------------------------------------------------------
// Crit-bit lowest set bit finder
// Finds the lowest set bit of a nonzero 64-bit word, one byte per cycle.
// ----------------------------------------------------------------------------
module cbkv_bitscan (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] diff,
    output logic        done,
    output logic [5:0]  pos
);

    logic [63:0] diff_reg;
    logic [2:0]  idx_reg;
    logic        run_reg;
    logic        done_reg;
    logic [5:0]  pos_reg;
    logic [7:0]  sel_byte;
    logic [2:0]  bit_pos;

    assign done = done_reg;
    assign pos  = pos_reg;

    always_comb
    begin
        sel_byte = diff_reg[{idx_reg, 3'b000} +: cbkv_pkg::SCAN_BITS];
        bit_pos  = 3'd0;
        for (int i = cbkv_pkg::SCAN_STEPS - 1; i >= 0; i--)
        begin
            if (sel_byte[i])
            begin
                bit_pos = 3'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg <= '0;
            idx_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                diff_reg <= diff;
                idx_reg  <= '0;
                run_reg  <= 1'b1;
            end
            else if (run_reg)
            begin
                if (sel_byte != '0)
                begin
                    pos_reg  <= {idx_reg, bit_pos};
                    done_reg <= 1'b1;
                    run_reg  <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
        end
    end

endmodule
